// ===== hdl/wpcl_pkg.sv =====
// Package for the windowed peak change logger: payload structs, state codes,
// sample width and the magnitude helper. Depends on nothing.
package wpcl_pkg;

    localparam int SAMPLE_WIDTH  = 16;
    localparam int TIME_WIDTH    = 64;
    localparam int CFG_WIDTH     = 16;
    localparam int CFG_IDX_WIDTH = 1;

    localparam logic [CFG_IDX_WIDTH-1:0] CFG_WINDOW_LENGTH = 1'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_ROUNDING_STEP = 1'd1;

    localparam logic [CFG_WIDTH-1:0] WINDOW_LENGTH_RESET = 16'd64;
    localparam logic [CFG_WIDTH-1:0] ROUNDING_STEP_RESET = 16'd10;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample;
        logic [TIME_WIDTH-1:0]          sample_time;
        logic                           frame_end;
    } wpcl_in_t;

    typedef struct packed {
        logic [TIME_WIDTH-1:0]          record_time;
        logic signed [SAMPLE_WIDTH-1:0] record_value;
        logic                           last_of_run;
    } wpcl_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FIN,
        ST_DRAIN
    } wpcl_state_t;

    // Unsigned magnitude; the most negative value maps to 2**(SAMPLE_WIDTH-1).
    function automatic logic [SAMPLE_WIDTH-1:0] wpcl_mag(input logic [SAMPLE_WIDTH-1:0] v);
        return v[SAMPLE_WIDTH-1] ? (~v + 1'b1) : v;
    endfunction

endpackage

// ===== hdl/wpcl_rem_serial.sv =====
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// Depends on wpcl_pkg for default widths.
module wpcl_rem_serial #(
    parameter int DIVIDEND_WIDTH = wpcl_pkg::SAMPLE_WIDTH,
    parameter int DIVISOR_WIDTH  = wpcl_pkg::CFG_WIDTH
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [DIVIDEND_WIDTH-1:0] dividend,
    input  logic [DIVISOR_WIDTH-1:0]  divisor,
    output logic                      done,
    output logic [DIVISOR_WIDTH-1:0]  remainder
);
    import wpcl_pkg::*;

    localparam int CW = (DIVIDEND_WIDTH > 1) ? $clog2(DIVIDEND_WIDTH) : 1;

    logic [DIVIDEND_WIDTH-1:0] shift_reg;
    logic [DIVISOR_WIDTH-1:0]  rem_reg;
    logic [DIVISOR_WIDTH-1:0]  divisor_reg;
    logic [CW-1:0]             cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;

    logic [DIVISOR_WIDTH:0]    trial;
    logic [DIVISOR_WIDTH:0]    diff;
    logic [DIVISOR_WIDTH-1:0]  rem_next;

    always_comb
    begin
        trial = {rem_reg, shift_reg[DIVIDEND_WIDTH-1]};
        diff  = trial - {1'b0, divisor_reg};
        if (trial >= {1'b0, divisor_reg})
        begin
            rem_next = diff[DIVISOR_WIDTH-1:0];
        end
        else
        begin
            rem_next = trial[DIVISOR_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DIVIDEND_WIDTH - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg   <= dividend;
            rem_reg     <= '0;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            shift_reg <= {shift_reg[DIVIDEND_WIDTH-2:0], 1'b0};
            rem_reg   <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

`ifndef ASSERT_OFF
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !$rose(busy_reg) |-> rem_reg < divisor_reg)
        else $error("partial remainder not below divisor");
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg && $past(busy_reg))
        else $error("done without a finished iteration");
    a_busy_length: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg)
        else $error("start did not begin iteration");
`endif

endmodule

// ===== hdl/windowed_peak_change_logger.sv =====
// Windowed peak change logger, top level. Depends on wpcl_pkg and the
// serial remainder unit wpcl_rem_serial.
//
// Usage: one sample transaction is taken whenever in_ready is high. A sample
// that does not close its window leaves in_ready high. A sample that closes
// its window (count reaches window_length, or frame_end set) keeps the input
// closed while the window peak magnitude is divided by rounding_step one
// bit per cycle in the serial remainder unit; then the quantized value
// |peak| - remainder is signed and compared against the held value in the
// finishing state, which waits if the output register still holds an
// untaken record. A close emits zero, one or two records (previous held
// record, then the new one); when two are due the second leaves in the
// cycle after the first is taken, and the input stays closed until then,
// so such a close lasts longer. Registers are written through
// cfg_write/cfg_index/cfg_data while no close is in flight; a zero
// window_length or rounding_step acts as one.
module windowed_peak_change_logger (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  wpcl_pkg::wpcl_in_t                   in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output wpcl_pkg::wpcl_out_t                  out_data,
    input  logic                                 cfg_write,
    input  logic [wpcl_pkg::CFG_IDX_WIDTH-1:0]   cfg_index,
    input  logic [wpcl_pkg::CFG_WIDTH-1:0]       cfg_data
);
    import wpcl_pkg::*;

    localparam int SW = SAMPLE_WIDTH;

    // Configuration
    logic [CFG_WIDTH-1:0] wl_reg;
    logic [CFG_WIDTH-1:0] step_reg;

    // Window and record state
    wpcl_state_t           state_reg, state_next;
    logic [CFG_WIDTH-1:0]  count_reg;
    logic [TIME_WIDTH-1:0] start_time_reg;
    logic signed [SW-1:0]  peak_reg;
    logic [TIME_WIDTH-1:0] held_time_reg;
    logic signed [SW-1:0]  held_value_reg;
    logic [TIME_WIDTH-1:0] emitted_reg;

    // Output register plus one pending record
    logic      out_valid_reg, out_valid_next;
    wpcl_out_t out_data_reg, out_data_next;
    wpcl_out_t pend_reg;

    // Accept-side datapath
    logic                  accept;
    logic [SW-1:0]         mag_s;
    logic signed [SW-1:0]  peak_new;
    logic [CFG_WIDTH-1:0]  count_inc;
    logic [CFG_WIDTH-1:0]  len_eff;
    logic [CFG_WIDTH-1:0]  step_eff;
    logic                  close;

    // Finishing datapath
    logic                  div_start;
    logic                  div_done;
    logic [CFG_WIDTH-1:0]  div_rem;
    logic [SW-1:0]         peak_mag;
    logic [SW-1:0]         qmag;
    logic signed [SW-1:0]  q;
    logic                  changed;
    logic                  emit_a;
    logic                  emit_b;
    logic [TIME_WIDTH-1:0] emitted_after_a;
    logic                  out_free;
    logic                  fin_fire;
    logic                  drain_fire;
    wpcl_out_t             rec_a;
    wpcl_out_t             rec_b;

    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign len_eff  = (wl_reg == '0) ? CFG_WIDTH'(1) : wl_reg;
    assign step_eff = (step_reg == '0) ? CFG_WIDTH'(1) : step_reg;

    // Window update: first sample sets start and peak, later ones replace the
    // peak only on strictly larger magnitude so the earlier sample wins ties.
    always_comb
    begin
        mag_s     = wpcl_mag(in_data.sample);
        count_inc = count_reg + 1'b1;
        if (count_reg == '0)
        begin
            peak_new = in_data.sample;
        end
        else if (mag_s > wpcl_mag(peak_reg))
        begin
            peak_new = in_data.sample;
        end
        else
        begin
            peak_new = peak_reg;
        end
        close = (count_inc >= len_eff) || in_data.frame_end;
    end

    // Quantize toward zero: |q| = |peak| - (|peak| mod step), sign restored.
    // Then decide which of the two records survive the time filter.
    always_comb
    begin
        peak_mag        = wpcl_mag(peak_reg);
        qmag            = peak_mag - SW'(div_rem);
        q               = peak_reg[SW-1] ? -$signed(qmag) : $signed(qmag);
        changed         = (q != held_value_reg);
        emit_a          = changed && (held_time_reg != '0) && (held_time_reg != emitted_reg);
        emitted_after_a = emit_a ? held_time_reg : emitted_reg;
        emit_b          = changed && (start_time_reg != '0)
                          && (start_time_reg != emitted_after_a);
        rec_a.record_time  = held_time_reg;
        rec_a.record_value = held_value_reg;
        rec_a.last_of_run  = !emit_b;
        rec_b.record_time  = start_time_reg;
        rec_b.record_value = q;
        rec_b.last_of_run  = 1'b1;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && close)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = (emit_a && emit_b) ? ST_DRAIN : ST_IDLE;
                end
            end
            ST_DRAIN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control outputs and output register loading
    always_comb
    begin
        in_ready   = (state_reg == ST_IDLE);
        div_start  = accept && close;
        fin_fire   = (state_reg == ST_FIN) && out_free;
        drain_fire = (state_reg == ST_DRAIN) && out_free;

        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        priority if (fin_fire)
        begin
            out_valid_next = emit_a || emit_b;
            out_data_next  = emit_a ? rec_a : rec_b;
        end
        else if (drain_fire)
        begin
            out_valid_next = 1'b1;
            out_data_next  = pend_reg;
        end
    end

    wpcl_rem_serial #(
        .DIVIDEND_WIDTH (SW),
        .DIVISOR_WIDTH  (CFG_WIDTH)
    ) u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (wpcl_mag(peak_new)),
        .divisor   (step_eff),
        .done      (div_done),
        .remainder (div_rem)
    );

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            wl_reg         <= WINDOW_LENGTH_RESET;
            step_reg       <= ROUNDING_STEP_RESET;
            count_reg      <= '0;
            start_time_reg <= '0;
            peak_reg       <= '0;
            held_time_reg  <= '0;
            held_value_reg <= '0;
            emitted_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;

            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_WINDOW_LENGTH: wl_reg   <= cfg_data;
                    CFG_ROUNDING_STEP: step_reg <= cfg_data;
                    default:           wl_reg   <= wl_reg;
                endcase
            end

            // Advance the window on every accepted sample
            if (accept)
            begin
                peak_reg  <= peak_new;
                count_reg <= close ? '0 : count_inc;
                if (count_reg == '0)
                begin
                    start_time_reg <= in_data.sample_time;
                end
            end

            // Every close replaces the held record, emitted or not
            if (fin_fire)
            begin
                held_time_reg  <= start_time_reg;
                held_value_reg <= q;
                emitted_reg    <= emit_b ? start_time_reg : emitted_after_a;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        if (fin_fire)
        begin
            pend_reg <= rec_b;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef ASSERT_OFF
    a_drain_has_first: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DRAIN |-> out_valid_reg && !out_data_reg.last_of_run)
        else $error("second record pending without first in output");
    a_not_last_means_pending: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_data_reg.last_of_run |-> state_reg == ST_DRAIN)
        else $error("non-final record with nothing pending");
    a_fin_updates_held: assert property (@(posedge clk) disable iff (!rst_n)
        fin_fire |=> held_time_reg == $past(start_time_reg))
        else $error("held record not replaced at window close");
    a_no_accept_during_close: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |=> !in_ready ##1 !in_ready)
        else $error("input opened during quantization");
`endif

endmodule

// ===== dv/windowed_peak_change_logger_tb.sv =====
// Self-checking testbench for windowed_peak_change_logger: directed table, then random phases,
// scored against typed records or an in-bench model of the window peak and record logic.
// Depends on wpcl_pkg and the RTL of the logger.
module windowed_peak_change_logger_tb;

    import wpcl_pkg::*;

    // Wait after a drain to cover the longest close, with slack for the second record.
    localparam int SETTLE_CYCLES   = SAMPLE_WIDTH + 8;
    localparam int ITEMS_PER_PHASE = 205;
    localparam int PHASE_COUNT     = 8;
    localparam int CYCLE_LIMIT     = 500000;
    localparam int PRINT_LIMIT     = 50;
    localparam int UNTYPED         = -1;

    localparam wpcl_out_t NO_REC = '0;

    typedef enum logic {
        ROW_SAMPLE,
        ROW_WRITE
    } row_kind_t;

    // One line of stimulus: a sample transaction or a register write.
    // typed_n < 0 means the expected records come from the model below.
    typedef struct {
        row_kind_t                kind;
        wpcl_in_t                 item;
        int                       typed_n;
        wpcl_out_t                rec0;
        wpcl_out_t                rec1;
        logic [CFG_IDX_WIDTH-1:0] reg_idx;
        logic [CFG_WIDTH-1:0]     reg_val;
    } stim_row_t;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    wpcl_in_t                 in_data;
    logic                     out_valid;
    logic                     out_ready;
    wpcl_out_t                out_data;
    logic                     cfg_write;
    logic [CFG_IDX_WIDTH-1:0] cfg_index;
    logic [CFG_WIDTH-1:0]     cfg_data;

    // Model of the block: configuration, open window and held record.
    logic [CFG_WIDTH-1:0]     model_len;
    logic [CFG_WIDTH-1:0]     model_step;
    logic [15:0]              win_count;
    logic [TIME_WIDTH-1:0]    win_start;
    int                       win_peak;
    logic [TIME_WIDTH-1:0]    held_time;
    int                       held_value;
    logic [TIME_WIDTH-1:0]    emitted_time;

    wpcl_out_t                pending_records[$];
    wpcl_out_t                fresh_records[$];
    stim_row_t                directed_rows[$];

    int                       send_idle_pct;
    int                       recv_idle_pct;
    int                       mismatches;
    int                       cycle_count;
    logic [TIME_WIDTH-1:0]    stamp_ns;
    wpcl_out_t                want_rec;

    windowed_peak_change_logger dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    // Stop a hung run.
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Receiver: stall at random, at the rate of the current phase.
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatches < PRINT_LIMIT)
            $display("%0t: %s: got %0h, want %0h", $time, what, got, want);
        mismatches = mismatches + 1;
    endtask

    // Score every record transaction against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_records.size() == 0)
                report_mismatch("record with nothing pending", out_data.record_time, 64'd0);
            else
            begin
                want_rec = pending_records.pop_front();
                if (out_data.record_time !== want_rec.record_time)
                    report_mismatch("record_time", out_data.record_time,
                                    want_rec.record_time);
                if (out_data.record_value !== want_rec.record_value)
                    report_mismatch("record_value", 64'(out_data.record_value),
                                    64'(want_rec.record_value));
                if (out_data.last_of_run !== want_rec.last_of_run)
                    report_mismatch("last_of_run", 64'(out_data.last_of_run),
                                    64'(want_rec.last_of_run));
            end
        end
    end

    function automatic int mag(int v);
        return (v < 0) ? -v : v;
    endfunction

    // Emit the held record unless its time is zero or already went out.
    function automatic void offer_held();
        wpcl_out_t r;
        if (held_time != 0 && held_time != emitted_time)
        begin
            r.record_time  = held_time;
            r.record_value = held_value[SAMPLE_WIDTH-1:0];
            r.last_of_run  = 1'b0;
            fresh_records.push_back(r);
            emitted_time = held_time;
        end
    endfunction

    // Advance the model by one accepted sample; queue its records when keep is set.
    function automatic void advance_window(input wpcl_in_t item, input bit keep);
        wpcl_out_t r;
        int        s_val;
        int        span;
        int        divisor;
        int        quant;
        bit        moved;
        s_val = $signed(item.sample);
        span  = (model_len == 0) ? 1 : int'(model_len);
        fresh_records.delete();
        if (win_count == 0)
        begin
            win_start = item.sample_time;
            win_peak  = s_val;
        end
        else if (mag(s_val) > mag(win_peak))
            win_peak = s_val;
        win_count = win_count + 1'b1;
        if (win_count >= span || item.frame_end)
        begin
            divisor   = (model_step == 0) ? 1 : int'(model_step);
            quant     = (win_peak / divisor) * divisor;
            moved     = (quant != held_value);
            win_count = '0;
            if (moved)
                offer_held();
            held_time  = win_start;
            held_value = quant;
            if (moved)
                offer_held();
            // Flag the final record of this close.
            if (fresh_records.size() != 0)
            begin
                r = fresh_records.pop_back();
                r.last_of_run = 1'b1;
                fresh_records.push_back(r);
            end
        end
        if (keep)
            foreach (fresh_records[i])
                pending_records.push_back(fresh_records[i]);
    endfunction

    // Hold off the sender until every expected record is taken, then let any
    // close that yields no record run out.
    task automatic drain_outputs();
        in_valid <= 1'b0;
        while (pending_records.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx,
                             input logic [CFG_WIDTH-1:0] val);
        drain_outputs();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
        if (idx == CFG_WINDOW_LENGTH)
            model_len = val;
        else
            model_step = val;
    endtask

    // Drive one row; entered and left at a falling edge.
    task automatic send_row(input stim_row_t row);
        int gap;
        if (row.kind == ROW_WRITE)
            write_reg(row.reg_idx, row.reg_val);
        else
        begin
            gap = 0;
            while ($urandom_range(0, 99) < send_idle_pct)
                gap = gap + 1;
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            in_data  <= row.item;
            in_valid <= 1'b1;
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            advance_window(row.item, row.typed_n == UNTYPED);
            if (row.typed_n > 0)
                pending_records.push_back(row.rec0);
            if (row.typed_n > 1)
                pending_records.push_back(row.rec1);
            @(negedge clk);
        end
    endtask

    function automatic wpcl_out_t rec(input logic [63:0] t, input int v, input bit last);
        wpcl_out_t r;
        r.record_time  = t;
        r.record_value = v[SAMPLE_WIDTH-1:0];
        r.last_of_run  = last;
        return r;
    endfunction

    function automatic stim_row_t s_row(input int s, input logic [63:0] t, input bit fe,
                                        input int n_typed, input wpcl_out_t r0,
                                        input wpcl_out_t r1);
        stim_row_t row;
        row.kind             = ROW_SAMPLE;
        row.item.sample      = s[SAMPLE_WIDTH-1:0];
        row.item.sample_time = t;
        row.item.frame_end   = fe;
        row.typed_n          = n_typed;
        row.rec0             = r0;
        row.rec1             = r1;
        row.reg_idx          = '0;
        row.reg_val          = '0;
        return row;
    endfunction

    function automatic stim_row_t c_row(input logic [CFG_IDX_WIDTH-1:0] idx,
                                        input logic [CFG_WIDTH-1:0] val);
        stim_row_t row;
        row         = s_row(0, 0, 1'b0, 0, NO_REC, NO_REC);
        row.kind    = ROW_WRITE;
        row.reg_idx = idx;
        row.reg_val = val;
        return row;
    endfunction

    // Random sample: mostly full range, some extremes and small values; time
    // mostly advancing, with zero, repeated and arbitrary stamps mixed in.
    function automatic stim_row_t random_row(input int fe_pct);
        int          pick;
        logic [15:0] s_bits;
        logic [63:0] t;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            s_bits = 16'h8000;
        else if (pick == 1)
            s_bits = 16'h7fff;
        else if (pick < 4)
            s_bits = 16'($urandom_range(0, 60)) - 16'd30;
        else
            s_bits = 16'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 3)
            t = '0;
        else if (pick < 6)
            t = stamp_ns;
        else if (pick < 10)
            t = {$urandom, $urandom};
        else
        begin
            stamp_ns = stamp_ns + 64'($urandom_range(1, 5000));
            t = stamp_ns;
        end
        return s_row(int'($signed(s_bits)), t, $urandom_range(0, 99) < fe_pct,
                     UNTYPED, NO_REC, NO_REC);
    endfunction

    initial
    begin
        int len_v;
        int step_v;
        int fe_pct;

        clk           = 1'b0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        out_ready     = 1'b0;
        cfg_write     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        model_len     = WINDOW_LENGTH_RESET;
        model_step    = ROUNDING_STEP_RESET;
        win_count     = '0;
        win_start     = '0;
        win_peak      = 0;
        held_time     = '0;
        held_value    = 0;
        emitted_time  = '0;
        mismatches    = 0;
        cycle_count   = 0;
        stamp_ns      = 64'd100000;
        send_idle_pct = 18;
        recv_idle_pct = 67;

        // Directed rows; reset values in force first (window 64, step 10).
        directed_rows.push_back(s_row(25, 100, 1, 1, rec(100, 20, 1), NO_REC));
        // Negative peak truncates toward zero.
        directed_rows.push_back(s_row(-37, 200, 1, 1, rec(200, -30, 1), NO_REC));
        // Unchanged value: held record moves to 300, nothing goes out.
        directed_rows.push_back(s_row(31, 300, 0, 0, NO_REC, NO_REC));
        directed_rows.push_back(s_row(-39, 310, 1, 0, NO_REC, NO_REC));
        // Change with a fresh held record: both records go out.
        directed_rows.push_back(s_row(5, 400, 1, 2, rec(300, -30, 0), rec(400, 0, 1)));
        // Zero timestamps suppress both records.
        directed_rows.push_back(s_row(0, 0, 1, 0, NO_REC, NO_REC));
        directed_rows.push_back(s_row(15, 0, 1, 0, NO_REC, NO_REC));
        // New record time equals the last emitted time: suppressed.
        directed_rows.push_back(s_row(20, 400, 1, 0, NO_REC, NO_REC));
        // Equal magnitudes: the earlier sample keeps the peak.
        directed_rows.push_back(s_row(30, 500, 0, UNTYPED, NO_REC, NO_REC));
        directed_rows.push_back(s_row(-30, 501, 1, UNTYPED, NO_REC, NO_REC));
        directed_rows.push_back(s_row(-30, 600, 0, UNTYPED, NO_REC, NO_REC));
        directed_rows.push_back(s_row(30, 601, 1, UNTYPED, NO_REC, NO_REC));
        // One-sample windows, no quantization: sample and time extremes.
        directed_rows.push_back(c_row(CFG_WINDOW_LENGTH, 16'd1));
        directed_rows.push_back(c_row(CFG_ROUNDING_STEP, 16'd1));
        directed_rows.push_back(s_row(32767, 700, 0, 1, rec(700, 32767, 1), NO_REC));
        directed_rows.push_back(s_row(-32768, '1, 0, 1, rec('1, -32768, 1), NO_REC));
        directed_rows.push_back(s_row(-32767, 800, 0, 1, rec(800, -32767, 1), NO_REC));
        // Zero length and zero step act as one.
        directed_rows.push_back(c_row(CFG_WINDOW_LENGTH, 16'd0));
        directed_rows.push_back(c_row(CFG_ROUNDING_STEP, 16'd0));
        directed_rows.push_back(s_row(12345, 900, 0, 1, rec(900, 12345, 1), NO_REC));
        // Largest length and a step of 32768; most negative sample stays a full step.
        directed_rows.push_back(c_row(CFG_WINDOW_LENGTH, 16'hffff));
        directed_rows.push_back(c_row(CFG_ROUNDING_STEP, 16'h8000));
        directed_rows.push_back(s_row(-32768, 1000, 1, 1, rec(1000, -32768, 1), NO_REC));
        directed_rows.push_back(s_row(32767, 1100, 1, 1, rec(1100, 0, 1), NO_REC));

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_row(directed_rows[i]);

        // Random phases, each with its own register setting; phases 0-2, 3-5 and 6-7 share an idle pattern.
        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            case (ph)
                0:       begin len_v = 1;     step_v = 1;     fe_pct = 10; end
                1:       begin len_v = 0;     step_v = 0;     fe_pct = 10; end
                2:       begin len_v = $urandom_range(2, 8);
                               step_v = $urandom_range(1, 200);    fe_pct = 15; end
                3:       begin len_v = 65535; step_v = 32768; fe_pct = 25; end
                4:       begin len_v = $urandom_range(1, 16);
                               step_v = 65535;                     fe_pct = 20; end
                5:       begin len_v = $urandom_range(3, 64);
                               step_v = $urandom_range(1, 20);     fe_pct = 5;  end
                6:       begin len_v = 64;    step_v = 10;    fe_pct = 5;  end
                default: begin len_v = $urandom_range(1, 4);
                               step_v = $urandom_range(1, 32768);  fe_pct = 30; end
            endcase
            if (ph < 3)
            begin
                send_idle_pct = 18;
                recv_idle_pct = 67;
            end
            else if (ph < 6)
            begin
                send_idle_pct = 67;
                recv_idle_pct = 18;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_reg(CFG_WINDOW_LENGTH, len_v[CFG_WIDTH-1:0]);
            write_reg(CFG_ROUNDING_STEP, step_v[CFG_WIDTH-1:0]);
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                // Hold the sender now and then until the output side is empty.
                if (k == 100 || $urandom_range(0, 199) == 0)
                    drain_outputs();
                send_row(random_row(fe_pct));
            end
        end

        drain_outputs();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
